[rtl/sensor_frame_crc_decoder_macros.svh]
// Assertion macros shared by the sensor frame decoder modules.
`ifndef SENSOR_FRAME_CRC_DECODER_MACROS_SVH
`define SENSOR_FRAME_CRC_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFCD_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sfcd_pkg.sv]
// Shared types, constants and CRC functions for the sensor frame decoder.
package sfcd_pkg;

    localparam logic [7:0]  StartMask  = 8'h90;
    localparam logic [7:0]  CrcPoly    = 8'h31;
    localparam logic [6:0]  HumLimit   = 7'd100;
    localparam logic [6:0]  DualLimit  = 7'd125;
    localparam logic [10:0] TempOffset = 11'd400;
    localparam logic [10:0] Weight100  = 11'd100;
    localparam logic [10:0] Weight10   = 11'd10;
    localparam logic [3:0]  DigitBase  = 4'd10;

    // Reciprocals: ceil(2^16/10) and ceil(2^19/100), exact for magnitudes below 2048
    localparam logic [23:0] Recip10  = 24'd6554;
    localparam logic [23:0] Recip100 = 24'd5243;

    // Decoded fields that ride unchanged through the temperature stages
    typedef struct packed {
        logic [6:0] sensor_id;
        logic       new_battery;
        logic       weak_battery;
        logic [6:0] humidity;
        logic       no_humidity;
    } info_t;

    // Raw temperature nibbles
    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } bcd_t;

    // Bit-serial CRC-8, MSB first, zero initial value; elaboration use only
    function automatic logic [7:0] crc8_serial(input logic [31:0] word);
        logic [7:0] crc;
        logic       top;
        crc = '0;
        for (int i = 31; i >= 0; i--) begin
            top = crc[7] ^ word[i];
            crc = {crc[6:0], 1'b0};
            if (top) begin
                crc = crc ^ CrcPoly;
            end
        end
        return crc;
    endfunction

    // Contribution of each word bit to the CRC (the CRC is linear)
    function automatic logic [31:0][7:0] crc8_columns();
        logic [31:0][7:0] cols;
        for (int i = 0; i < 32; i++) begin
            cols[i] = crc8_serial(32'd1 << i);
        end
        return cols;
    endfunction

    localparam logic [31:0][7:0] CrcColumns = crc8_columns();

    // Flat XOR tree over the 32 frame bits
    function automatic logic [7:0] crc8_word(input logic [31:0] word);
        logic [7:0] crc;
        crc = '0;
        for (int i = 0; i < 32; i++) begin
            if (word[i]) begin
                crc = crc ^ CrcColumns[i];
            end
        end
        return crc;
    endfunction

endpackage

[rtl/sensor_frame_crc_decoder.sv]
// Top level of the sensor frame decoder: four-stage decode pipeline.
// Frames move through four registers in order: check, temperature, divide, remainder.
// One frame per cycle unless m_ready stalls; each registered stage holds one frame.
// Frames with bad start bits or a CRC mismatch are dropped in the first stage.
// Reset (aresetn low, synchronous) clears every stage's valid bit; no clearing pass.
module sensor_frame_crc_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_frame_byte0,
    input  logic [7:0]  s_frame_byte1,
    input  logic [7:0]  s_frame_byte2,
    input  logic [7:0]  s_frame_byte3,
    input  logic [7:0]  s_frame_byte4,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_sensor_id,
    output logic        m_new_battery,
    output logic        m_weak_battery,
    output logic        m_below_zero,
    output logic [6:0]  m_humidity,
    output logic        m_no_humidity,
    output logic [10:0] m_temp_magnitude,
    output logic [3:0]  m_tenths_digit,
    output logic [3:0]  m_ones_digit,
    output logic [3:0]  m_tens_digit
);

    logic            chk_valid;
    logic            chk_ready;
    sfcd_pkg::info_t chk_info;
    sfcd_pkg::bcd_t  chk_bcd;

    logic            tmp_valid;
    logic            tmp_ready;
    sfcd_pkg::info_t tmp_info;
    logic            tmp_neg;
    logic [10:0]     tmp_mag;

    logic            div_valid;
    logic            div_ready;
    sfcd_pkg::info_t div_info;
    logic            div_neg;
    logic [10:0]     div_mag;
    logic [6:0]      div_quot10;
    logic [3:0]      div_quot100;

    sfcd_pkg::info_t out_info;

    // Validate frame and extract fields
    sfcd_frame_check u_frame_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .frame_byte0 (s_frame_byte0),
        .frame_byte1 (s_frame_byte1),
        .frame_byte2 (s_frame_byte2),
        .frame_byte3 (s_frame_byte3),
        .frame_byte4 (s_frame_byte4),
        .out_valid   (chk_valid),
        .out_ready   (chk_ready),
        .out_info    (chk_info),
        .out_bcd     (chk_bcd)
    );

    // Form signed temperature as sign and magnitude
    sfcd_temp_calc u_temp_calc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (chk_valid),
        .in_ready       (chk_ready),
        .in_info        (chk_info),
        .in_bcd         (chk_bcd),
        .out_valid      (tmp_valid),
        .out_ready      (tmp_ready),
        .out_info       (tmp_info),
        .out_below_zero (tmp_neg),
        .out_magnitude  (tmp_mag)
    );

    // Divide magnitude by 10 and 100
    sfcd_digit_div u_digit_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (tmp_valid),
        .in_ready       (tmp_ready),
        .in_info        (tmp_info),
        .in_below_zero  (tmp_neg),
        .in_magnitude   (tmp_mag),
        .out_valid      (div_valid),
        .out_ready      (div_ready),
        .out_info       (div_info),
        .out_below_zero (div_neg),
        .out_magnitude  (div_mag),
        .out_quot10     (div_quot10),
        .out_quot100    (div_quot100)
    );

    // Split into decimal digits and hold the result for transfer
    sfcd_digit_rem u_digit_rem (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_info        (div_info),
        .in_below_zero  (div_neg),
        .in_magnitude   (div_mag),
        .in_quot10      (div_quot10),
        .in_quot100     (div_quot100),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_info       (out_info),
        .out_below_zero (m_below_zero),
        .out_magnitude  (m_temp_magnitude),
        .out_tenths     (m_tenths_digit),
        .out_ones       (m_ones_digit),
        .out_tens       (m_tens_digit)
    );

    assign m_sensor_id    = out_info.sensor_id;
    assign m_new_battery  = out_info.new_battery;
    assign m_weak_battery = out_info.weak_battery;
    assign m_humidity     = out_info.humidity;
    assign m_no_humidity  = out_info.no_humidity;

endmodule

[rtl/sfcd_frame_check.sv]
// Stage 1: header and CRC check, field extraction and humidity rules.
`include "sensor_frame_crc_decoder_macros.svh"

module sfcd_frame_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       frame_byte0,
    input  logic [7:0]       frame_byte1,
    input  logic [7:0]       frame_byte2,
    input  logic [7:0]       frame_byte3,
    input  logic [7:0]       frame_byte4,
    output logic             out_valid,
    input  logic             out_ready,
    output sfcd_pkg::info_t  out_info,
    output sfcd_pkg::bcd_t   out_bcd
);

    logic            valid_reg;
    logic            valid_next;
    logic            header_ok;
    logic            crc_ok;
    logic [6:0]      raw_hum;
    logic            hum_over;
    logic            dual_temp;
    sfcd_pkg::info_t info_reg;
    sfcd_pkg::info_t info_next;
    sfcd_pkg::bcd_t  bcd_reg;
    sfcd_pkg::bcd_t  bcd_next;

    // Check start bits and CRC
    assign header_ok = (frame_byte0 & sfcd_pkg::StartMask) == sfcd_pkg::StartMask;
    assign crc_ok    = sfcd_pkg::crc8_word({frame_byte0, frame_byte1,
                                            frame_byte2, frame_byte3}) == frame_byte4;
    assign valid_next = in_valid && header_ok && crc_ok;

    // Extract fields and apply humidity rules
    assign raw_hum   = frame_byte3[6:0];
    assign hum_over  = raw_hum >= sfcd_pkg::HumLimit;
    assign dual_temp = raw_hum >= sfcd_pkg::DualLimit;

    always_comb begin
        info_next.sensor_id    = {dual_temp, frame_byte0[3:0], frame_byte1[7:6]};
        info_next.new_battery  = frame_byte1[5];
        info_next.weak_battery = frame_byte3[7];
        info_next.humidity     = hum_over ? 7'd0 : raw_hum;
        info_next.no_humidity  = hum_over || (raw_hum == 7'd0);
        bcd_next.hundreds      = frame_byte1[3:0];
        bcd_next.tens          = frame_byte2[7:4];
        bcd_next.units         = frame_byte2[3:0];
    end

    // Advance when the stage is empty or its contents move on; drop bad frames
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            info_reg <= info_next;
            bcd_reg  <= bcd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;
    assign out_bcd   = bcd_reg;

    `SFCD_ASSERT_NEXT(a_bad_header_dropped, aclk, aresetn, in_valid && in_ready && !header_ok, !valid_reg, "frame with bad start bits passed")
    `SFCD_ASSERT_IMPLIES(a_humidity_range, aclk, aresetn, valid_reg, info_reg.humidity < sfcd_pkg::HumLimit, "humidity out of range")

endmodule

[rtl/sfcd_temp_calc.sv]
// Stage 2: weighted nibble sum, offset removal, sign and magnitude.
module sfcd_temp_calc (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfcd_pkg::info_t  in_info,
    input  sfcd_pkg::bcd_t   in_bcd,
    output logic             out_valid,
    input  logic             out_ready,
    output sfcd_pkg::info_t  out_info,
    output logic             out_below_zero,
    output logic [10:0]      out_magnitude
);

    logic            valid_reg;
    logic [10:0]     sum;
    logic            neg_next;
    logic [10:0]     mag_next;
    sfcd_pkg::info_t info_reg;
    logic            neg_reg;
    logic [10:0]     mag_reg;

    // Weight nibbles 100/10/1 and take distance from the offset
    assign sum = 11'(in_bcd.hundreds) * sfcd_pkg::Weight100
               + 11'(in_bcd.tens) * sfcd_pkg::Weight10
               + 11'(in_bcd.units);
    assign neg_next = sum < sfcd_pkg::TempOffset;
    assign mag_next = neg_next ? (sfcd_pkg::TempOffset - sum) : (sum - sfcd_pkg::TempOffset);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            info_reg <= in_info;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_info       = info_reg;
    assign out_below_zero = neg_reg;
    assign out_magnitude  = mag_reg;

endmodule

[rtl/sfcd_digit_div.sv]
// Stage 3: quotients by 10 and 100 through reciprocal multiplication.
module sfcd_digit_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfcd_pkg::info_t  in_info,
    input  logic             in_below_zero,
    input  logic [10:0]      in_magnitude,
    output logic             out_valid,
    input  logic             out_ready,
    output sfcd_pkg::info_t  out_info,
    output logic             out_below_zero,
    output logic [10:0]      out_magnitude,
    output logic [6:0]       out_quot10,
    output logic [3:0]       out_quot100
);

    logic            valid_reg;
    logic [23:0]     prod10;
    logic [23:0]     prod100;
    sfcd_pkg::info_t info_reg;
    logic            neg_reg;
    logic [10:0]     mag_reg;
    logic [6:0]      quot10_reg;
    logic [3:0]      quot100_reg;

    // Divide by constants: multiply by scaled reciprocal, keep the high bits
    assign prod10  = 24'(in_magnitude) * sfcd_pkg::Recip10;
    assign prod100 = 24'(in_magnitude) * sfcd_pkg::Recip100;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            info_reg    <= in_info;
            neg_reg     <= in_below_zero;
            mag_reg     <= in_magnitude;
            quot10_reg  <= prod10[22:16];
            quot100_reg <= prod100[22:19];
        end
    end

    assign out_valid      = valid_reg;
    assign out_info       = info_reg;
    assign out_below_zero = neg_reg;
    assign out_magnitude  = mag_reg;
    assign out_quot10     = quot10_reg;
    assign out_quot100    = quot100_reg;

endmodule

[rtl/sfcd_digit_rem.sv]
// Stage 4: decimal digits from the quotients; output register.
`include "sensor_frame_crc_decoder_macros.svh"

module sfcd_digit_rem (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfcd_pkg::info_t  in_info,
    input  logic             in_below_zero,
    input  logic [10:0]      in_magnitude,
    input  logic [6:0]       in_quot10,
    input  logic [3:0]       in_quot100,
    output logic             out_valid,
    input  logic             out_ready,
    output sfcd_pkg::info_t  out_info,
    output logic             out_below_zero,
    output logic [10:0]      out_magnitude,
    output logic [3:0]       out_tenths,
    output logic [3:0]       out_ones,
    output logic [3:0]       out_tens
);

    logic            valid_reg;
    logic [10:0]     tenths_wide;
    logic [6:0]      ones_wide;
    logic [3:0]      tens_next;
    sfcd_pkg::info_t info_reg;
    logic            neg_reg;
    logic [10:0]     mag_reg;
    logic [3:0]      tenths_reg;
    logic [3:0]      ones_reg;
    logic [3:0]      tens_reg;
    logic [10:0]     digit_sum;

    // Remainders; the hundreds quotient stays below 20, so one subtract folds it
    assign tenths_wide = in_magnitude - 11'(in_quot10) * sfcd_pkg::Weight10;
    assign ones_wide   = in_quot10 - 7'(11'(in_quot100) * sfcd_pkg::Weight10);
    assign tens_next   = (in_quot100 >= sfcd_pkg::DigitBase) ?
                         (in_quot100 - sfcd_pkg::DigitBase) : in_quot100;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            info_reg   <= in_info;
            neg_reg    <= in_below_zero;
            mag_reg    <= in_magnitude;
            tenths_reg <= tenths_wide[3:0];
            ones_reg   <= ones_wide[3:0];
            tens_reg   <= tens_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_info       = info_reg;
    assign out_below_zero = neg_reg;
    assign out_magnitude  = mag_reg;
    assign out_tenths     = tenths_reg;
    assign out_ones       = ones_reg;
    assign out_tens       = tens_reg;

    // Digits rebuild the magnitude, less any thousands place
    assign digit_sum = 11'(tens_reg) * sfcd_pkg::Weight100
                     + 11'(ones_reg) * sfcd_pkg::Weight10 + 11'(tenths_reg);

    `SFCD_ASSERT_IMPLIES(a_digits_decimal, aclk, aresetn, valid_reg, (tenths_reg < sfcd_pkg::DigitBase) && (ones_reg < sfcd_pkg::DigitBase) && (tens_reg < sfcd_pkg::DigitBase), "digit above nine")
    `SFCD_ASSERT_IMPLIES(a_digits_match, aclk, aresetn, valid_reg, (digit_sum == mag_reg) || (digit_sum + 11'd1000 == mag_reg), "digits disagree with magnitude")

endmodule
